/* rtl/cis_pkg.sv */
package cis_pkg;

    localparam int NUM_W = 52;
    localparam int DEN_W = 33;
    localparam int DIV_CNT_W = 6;
    localparam int ACC_W = 50;
    localparam int PROD_W = 64;
    localparam int SPLIT_W = 26;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CONTACT = 1'b1;

    localparam logic SIDE_A = 1'b0;
    localparam logic SIDE_B = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_LATB,
        ST_DOT,
        ST_CHECK,
        ST_NUM,
        ST_DIV,
        ST_MUL0,
        ST_MUL1,
        ST_KICK,
        ST_WRITE,
        ST_EMIT,
        ST_RERD,
        ST_RELAT
    } state_t;

    typedef struct packed {
        logic [31:0] inv_mass;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
    } body_t;

endpackage

/* rtl/cis_div.sv */
module cis_div
    import cis_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0]     q_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, q_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den};
    assign fits    = rem_sh >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_sub[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DEN_W-1:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/contact_impulse_solver.sv */
// Contact impulse solver over a table of BODY_COUNT bodies.
// Input beats on s_*: tuser is the command. Command write stores one body's
// velocity and inverse mass and gives no output beat. Command
// contact resolves bodies A and B along the given normal and gives two output
// beats on m_*: body A (tlast low), then body B (tlast high); tuser is the
// applied flag.
// The impulse magnitude comes from a 52-step restoring divider; the rest of a
// contact is reads, a dot product over the three components and per-component
// updates through the body memory (one read and one write port). A separating
// or massless contact skips the divider. One item is worked on at a time.
// After reset a clearing pass zeroes every entry of the body memory, with
// s_tready low. Output beats sit in a register; while the receiver stalls with a
// beat still held there, the solver holds at its next beat and accepts nothing new.
module contact_impulse_solver
    import cis_pkg::*;
#(
    parameter int BODY_COUNT = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index_a, index_b, normal_x, normal_y, normal_z, restitution,
    // write_vel_x, write_vel_y, write_vel_z, write_inv_mass
    input  logic [199:0] s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // body_index, vel_x, vel_y, vel_z, zero fill
    output logic [103:0] m_tdata,
    // applied
    output logic         m_tuser,
    output logic         m_tlast
);

    localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;

    function automatic logic [3:0] wrap_idx(input logic [3:0] idx);
        logic [3:0] v;
        v = idx;
        for (int i = 0; i < 8; i++) begin
            if (int'(v) >= BODY_COUNT) begin
                v = 4'(int'(v) - BODY_COUNT);
            end
        end
        return v;
    endfunction

    body_t mem [BODY_COUNT];
    body_t rdata_reg;
    logic  [AW-1:0] rd_addr;
    logic  [AW-1:0] wr_addr;
    body_t wr_data;
    logic  wr_en;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic side_reg;
    logic applied_reg;
    logic [1:0] comp_reg;

    logic [AW-1:0] a_reg, b_reg;
    logic signed [15:0] n_reg [3];
    logic [15:0] e_reg;
    logic signed [31:0] va_reg [3];
    logic signed [31:0] vb_reg [3];
    logic [31:0] ia_reg, ib_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [NUM_W-1:0] jm_reg;
    logic [PROD_W-1:0] prod_reg;

    logic m_valid_reg;
    logic [103:0] m_data_reg;
    logic m_user_reg, m_last_reg;

    logic in_acc;
    logic out_free;
    logic [AW-1:0] in_a, in_b;
    logic [DEN_W-1:0] inv_sum;
    logic [NUM_W-1:0] num_calc;
    logic div_done;
    logic [NUM_W-1:0] div_quot;
    logic [31:0] inv_sel;
    logic signed [15:0] n_sel;
    logic [15:0] n_mag;
    logic signed [31:0] v_sel;
    logic [PROD_W-1:0] kick_prod;
    logic signed [51:0] delta;
    logic signed [51:0] v_new;
    logic signed [31:0] v_sat;
    logic signed [32:0] diff;
    logic signed [48:0] dot_term;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_a     = AW'(wrap_idx(s_tdata[3:0]));
    assign in_b     = AW'(wrap_idx(s_tdata[7:4]));
    assign inv_sum  = {1'b0, ia_reg} + {1'b0, ib_reg};
    assign num_calc = NUM_W'(acc_reg[ACC_W-1:14]) * NUM_W'({1'b1, e_reg});

    cis_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_NUM),
        .num     (num_calc),
        .den     (inv_sum),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign inv_sel   = (side_reg == SIDE_B) ? ib_reg : ia_reg;
    assign n_sel     = n_reg[comp_reg];
    assign n_mag     = n_sel[15] ? 16'(-n_sel) : n_sel;
    assign v_sel     = (side_reg == SIDE_B) ? vb_reg[comp_reg] : va_reg[comp_reg];
    assign kick_prod = PROD_W'(prod_reg[PROD_W-1:16]) * PROD_W'(n_mag);
    assign delta     = (n_sel[15] ^ (side_reg == SIDE_B))
                       ? -$signed({2'b00, kick_prod[63:14]})
                       : $signed({2'b00, kick_prod[63:14]});
    assign v_new     = 52'(v_sel) + delta;
    assign v_sat     = (v_new > 52'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                       (v_new < -52'sh80000000) ? -32'sh80000000 : 32'(v_new);
    assign diff      = 33'(vb_reg[comp_reg]) - 33'(va_reg[comp_reg]);
    assign dot_term  = diff * n_sel;

    always_comb begin
        rd_addr = a_reg;
        wr_en   = 1'b0;
        wr_addr = a_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
            end
            ST_IDLE: begin
                if (in_acc && s_tuser == CMD_WRITE) begin
                    wr_en   = 1'b1;
                    wr_addr = in_a;
                    wr_data = '{inv_mass: s_tdata[199:168], vel_z: s_tdata[167:136],
                                vel_y: s_tdata[135:104], vel_x: s_tdata[103:72]};
                end
            end
            ST_RDB:  rd_addr = b_reg;
            ST_RERD: rd_addr = b_reg;
            ST_WRITE: begin
                wr_en = 1'b1;
                if (side_reg == SIDE_B) begin
                    wr_addr = b_reg;
                    wr_data = '{inv_mass: ib_reg, vel_z: vb_reg[2],
                                vel_y: vb_reg[1], vel_x: vb_reg[0]};
                end else begin
                    wr_data = '{inv_mass: ia_reg, vel_z: va_reg[2],
                                vel_y: va_reg[1], vel_x: va_reg[0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(BODY_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc && s_tuser == CMD_CONTACT) state_next = ST_RDA;
            end
            ST_RDA:   state_next = ST_RDB;
            ST_RDB:   state_next = ST_LATB;
            ST_LATB:  state_next = ST_DOT;
            ST_DOT: begin
                if (comp_reg == 2'd2) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (acc_reg[ACC_W-1] || inv_sum == '0) state_next = ST_EMIT;
                else state_next = ST_NUM;
            end
            ST_NUM:   state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) state_next = ST_MUL0;
            end
            ST_MUL0:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_KICK;
            ST_KICK: begin
                if (comp_reg == 2'd2) state_next = ST_WRITE;
            end
            ST_WRITE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (side_reg == SIDE_B) state_next = ST_IDLE;
                    else if (applied_reg) state_next = ST_RERD;
                end
            end
            ST_RERD:  state_next = ST_RELAT;
            ST_RELAT: state_next = ST_MUL0;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            side_reg    <= SIDE_A;
            applied_reg <= 1'b0;
            comp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_EMIT) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + AW'(1);
                ST_IDLE: begin
                    side_reg    <= SIDE_A;
                    applied_reg <= 1'b0;
                    comp_reg    <= '0;
                end
                ST_DOT:  comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                ST_CHECK: applied_reg <= !(acc_reg[ACC_W-1] || inv_sum == '0);
                ST_KICK: comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        side_reg    <= SIDE_B;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    a_reg    <= in_a;
                    b_reg    <= in_b;
                    n_reg[0] <= s_tdata[23:8];
                    n_reg[1] <= s_tdata[39:24];
                    n_reg[2] <= s_tdata[55:40];
                    e_reg    <= s_tdata[71:56];
                end
            end
            ST_RDB: begin
                va_reg[0] <= rdata_reg.vel_x;
                va_reg[1] <= rdata_reg.vel_y;
                va_reg[2] <= rdata_reg.vel_z;
                ia_reg    <= rdata_reg.inv_mass;
            end
            ST_LATB, ST_RELAT: begin
                vb_reg[0] <= rdata_reg.vel_x;
                vb_reg[1] <= rdata_reg.vel_y;
                vb_reg[2] <= rdata_reg.vel_z;
                ib_reg    <= rdata_reg.inv_mass;
                acc_reg   <= '0;
            end
            ST_DOT: acc_reg <= acc_reg + ACC_W'(dot_term);
            ST_DIV: begin
                if (div_done) jm_reg <= div_quot;
            end
            ST_MUL0: prod_reg <= PROD_W'(jm_reg[SPLIT_W-1:0]) * PROD_W'(inv_sel);
            ST_MUL1: prod_reg <= prod_reg +
                                 ((PROD_W'(jm_reg[NUM_W-1:SPLIT_W]) * PROD_W'(inv_sel))
                                  << SPLIT_W);
            ST_KICK: begin
                if (side_reg == SIDE_B) vb_reg[comp_reg] <= v_sat;
                else va_reg[comp_reg] <= v_sat;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_user_reg <= applied_reg;
                    m_last_reg <= side_reg;
                    if (side_reg == SIDE_B) begin
                        m_data_reg <= {4'b0000, vb_reg[2], vb_reg[1], vb_reg[0],
                                       4'(b_reg)};
                    end else begin
                        m_data_reg <= {4'b0000, va_reg[2], va_reg[1], va_reg[0],
                                       4'(a_reg)};
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* tb/testbench.sv */
module testbench;
    import cis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [3:0]  body;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        applied;
        logic        last;
    } body_report_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    logic signed [31:0] model_vx [16];
    logic signed [31:0] model_vy [16];
    logic signed [31:0] model_vz [16];
    logic [31:0]        model_inv [16];

    body_report_t pending_reports [$];
    int unsigned  errors = 0;
    int unsigned  cycles = 0;
    bit           quiet_rx = 1'b0;

    contact_impulse_solver #(.BODY_COUNT(16)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic signed [31:0] saturate(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [65:0] impulse_delta(input logic [63:0] k,
                                                         input logic signed [15:0] n);
        logic [15:0]  mag;
        logic [127:0] p;
        logic signed [65:0] d;
        mag = n[15] ? 16'(-n) : n;
        p = {64'd0, k} * {112'd0, mag};
        d = $signed({2'b00, p[77:14]});
        return n[15] ? -d : d;
    endfunction

    function automatic body_report_t snapshot(input int i, input logic ap, input logic lt);
        body_report_t r;
        r.body = i[3:0];
        r.vx = model_vx[i];
        r.vy = model_vy[i];
        r.vz = model_vz[i];
        r.applied = ap;
        r.last = lt;
        return r;
    endfunction

    task automatic resolve_contact(input int a, input int b, input logic signed [15:0] nx,
                                   input logic signed [15:0] ny, input logic signed [15:0] nz,
                                   input logic [15:0] e);
        logic signed [63:0] rel;
        logic [32:0]  msum;
        logic [127:0] num;
        logic [63:0]  jm;
        logic [63:0]  ka;
        logic [63:0]  kb;
        logic [95:0]  pr;
        rel = (64'(model_vx[b]) - 64'(model_vx[a])) * 64'(nx)
            + (64'(model_vy[b]) - 64'(model_vy[a])) * 64'(ny)
            + (64'(model_vz[b]) - 64'(model_vz[a])) * 64'(nz);
        msum = {1'b0, model_inv[a]} + {1'b0, model_inv[b]};
        if (rel < 0 || msum == 0) begin
            pending_reports.push_back(snapshot(a, 1'b0, 1'b0));
            pending_reports.push_back(snapshot(b, 1'b0, 1'b1));
            return;
        end
        num = {64'd0, 64'(rel) >> 14} * (128'd65536 + e);
        jm = 64'(num / msum);
        pr = {32'd0, jm} * model_inv[a];
        ka = pr[79:16];
        pr = {32'd0, jm} * model_inv[b];
        kb = pr[79:16];
        model_vx[a] = saturate(66'(model_vx[a]) + impulse_delta(ka, nx));
        model_vy[a] = saturate(66'(model_vy[a]) + impulse_delta(ka, ny));
        model_vz[a] = saturate(66'(model_vz[a]) + impulse_delta(ka, nz));
        pending_reports.push_back(snapshot(a, 1'b1, 1'b0));
        model_vx[b] = saturate(66'(model_vx[b]) - impulse_delta(kb, nx));
        model_vy[b] = saturate(66'(model_vy[b]) - impulse_delta(kb, ny));
        model_vz[b] = saturate(66'(model_vz[b]) - impulse_delta(kb, nz));
        pending_reports.push_back(snapshot(b, 1'b1, 1'b1));
    endtask

    task automatic send_beat(input logic cmd, input logic [3:0] a, input logic [3:0] b,
                             input logic [15:0] nx, input logic [15:0] ny,
                             input logic [15:0] nz, input logic [15:0] e,
                             input logic [31:0] wx, input logic [31:0] wy,
                             input logic [31:0] wz, input logic [31:0] wm,
                             input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {wm, wz, wy, wx, e, nz, ny, nx, b, a};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            model_vx[a] = wx;
            model_vy[a] = wy;
            model_vz[a] = wz;
            model_inv[a] = wm;
        end else begin
            resolve_contact(a, b, nx, ny, nz, e);
        end
    endtask

    always begin
        int stall;
        body_report_t want;
        stall = quiet_rx ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
            m_tready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
        m_tready <= 1'b1;
        do @(posedge aclk); while (!m_tvalid);
        if (pending_reports.size() == 0) begin
            report_mismatch("unexpected beat", m_tdata[35:4], 32'd0);
        end else begin
            want = pending_reports.pop_front();
            if (m_tdata[3:0] !== want.body)
                report_mismatch("body", 32'(m_tdata[3:0]), 32'(want.body));
            if (m_tdata[35:4] !== want.vx) report_mismatch("vel_x", m_tdata[35:4], want.vx);
            if (m_tdata[67:36] !== want.vy) report_mismatch("vel_y", m_tdata[67:36], want.vy);
            if (m_tdata[99:68] !== want.vz) report_mismatch("vel_z", m_tdata[99:68], want.vz);
            if (m_tuser !== want.applied)
                report_mismatch("applied", 32'(m_tuser), 32'(want.applied));
            if (m_tlast !== want.last)
                report_mismatch("last", 32'(m_tlast), 32'(want.last));
        end
    end

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'(16'($urandom));
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return $urandom;
            default: return $urandom_range(1, 32'h40000);
        endcase
    endfunction

    task automatic write_body(input logic [3:0] i, input bit no_gap = 1'b0);
        send_beat(CMD_WRITE, i, 4'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom),
                  rand_vel(), rand_vel(), rand_vel(), rand_mass(), no_gap);
    endtask

    task automatic send_contact(input logic [3:0] a, input logic [3:0] b,
                                input bit no_gap = 1'b0);
        send_beat(CMD_CONTACT, a, b, rand_normal(), rand_normal(), rand_normal(),
                  16'($urandom), $urandom, $urandom, $urandom, $urandom, no_gap);
    endtask

    task automatic test_directed();
        send_beat(CMD_CONTACT, 4'd0, 4'd1, 16'sd16384, 16'd0, 16'd0, 16'd0,
                  '0, '0, '0, '0);
        send_beat(CMD_WRITE, 4'd0, 4'd0, '0, '0, '0, '0,
                  32'h00010000, 32'd0, 32'd0, 32'h00010000);
        send_beat(CMD_WRITE, 4'd1, 4'd0, '0, '0, '0, '0,
                  32'hffff0000, 32'd0, 32'd0, 32'h00010000);
        send_beat(CMD_CONTACT, 4'd0, 4'd1, 16'sd16384, 16'd0, 16'd0, 16'd0,
                  '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd1, 4'd0, 16'sd16384, 16'd0, 16'd0, 16'hffff,
                  '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd0, 4'd1, -16'sd16384, 16'd0, 16'd0, 16'hffff,
                  '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd2, 4'd3, 16'sd16384, 16'sd16384, 16'sd16384, 16'hffff,
                  '0, '0, '0, '0);
        send_beat(CMD_WRITE, 4'd15, 4'd0, '0, '0, '0, '0,
                  32'h80000000, 32'h80000000, 32'h80000000, 32'hffffffff);
        send_beat(CMD_WRITE, 4'd14, 4'd0, '0, '0, '0, '0,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
        send_beat(CMD_CONTACT, 4'd14, 4'd15, -16'sd16384, -16'sd16384, -16'sd16384,
                  16'hffff, '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd15, 4'd14, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff,
                  '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd15, 4'd14, 16'sd16384, 16'sd16384, 16'sd16384,
                  16'hffff, '0, '0, '0, '0);
        send_beat(CMD_CONTACT, 4'd14, 4'd14, 16'sd16384, 16'd0, 16'd0, 16'd0,
                  '0, '0, '0, '0);
        send_beat(CMD_WRITE, 4'd5, 4'hf, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  32'h00020000, 32'h0, 32'h0, 32'h1);
        send_beat(CMD_CONTACT, 4'd5, 4'd5, 16'sd12000, -16'sd9000, 16'sd3000, 16'h8000,
                  '0, '0, '0, '0);
    endtask

    task automatic test_random_contacts(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) write_body(4'($urandom), $urandom_range(0, 3) == 0);
            else send_contact(4'($urandom), 4'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_back_to_back(input int count);
        quiet_rx = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 3 == 0) write_body(4'($urandom), 1'b1);
            else send_contact(4'($urandom), 4'($urandom), 1'b1);
        end
        quiet_rx = 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < 16; i++) begin
            model_vx[i] = '0;
            model_vy[i] = '0;
            model_vz[i] = '0;
            model_inv[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_contacts(1500);
        test_back_to_back(200);
        test_random_contacts(200);
        drain();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/cis_pkg.sv
rtl/cis_div.sv
rtl/contact_impulse_solver.sv
tb/testbench.sv
